// ----- design/dominator_set_and_idom_engine_macros.svh -----
// assertion macros for the dominator engine
`ifndef DOMINATOR_SET_AND_IDOM_ENGINE_MACROS_SVH
`define DOMINATOR_SET_AND_IDOM_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define DSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DSI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/dsi_pkg.sv -----
`default_nettype none
package dsi_pkg;
	localparam int MAX_BLOCKS_DEF = 32;
	localparam logic [1:0] KIND_BEGIN   = 2'd0;
	localparam logic [1:0] KIND_EDGE    = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	typedef struct packed {
		logic init;      // load initial sets
		logic relax;     // update block at row index
		logic dead_scan; // dead check at row index
		logic strip;     // strip dead from row index
		logic clr_chg;
		logic clr_dead;
	} dsi_cmd_t;

	typedef struct packed {
		logic changed;
		logic dead_grew;
	} dsi_sts_t;
endpackage
`default_nettype wire

// ----- design/dsi_datapath.sv -----
`default_nettype none
module dsi_datapath #(
	parameter int NB = dsi_pkg::MAX_BLOCKS_DEF,
	parameter int IW = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dsi_pkg::dsi_cmd_t    cmd,
	input  wire logic [IW-1:0]        row,
	input  wire logic [NB-1:0]        all,
	input  wire logic                 pm_clear,
	input  wire logic                 pm_wr,
	input  wire logic [IW-1:0]        pm_p,
	input  wire logic [IW-1:0]        pm_s,
	output dsi_pkg::dsi_sts_t         sts,
	output logic      [NB-1:0]        row_set,
	output logic      [NB-1:0]        dead_q,
	output logic      [NB-1:0]        sets_flat [NB]
);
	import dsi_pkg::*;
	logic [NB-1:0] pred_q [NB];
	logic [NB-1:0] dom_q  [NB];
	logic          chg_q, grew_q;
	logic [NB-1:0] meet, bitv;
	logic          relax_chg, dead_hit;

	always_comb begin
		bitv = '0;
		bitv[row] = 1'b1;
		meet = all;
		for (int p = 0; p < NB; p++)
			if (pred_q[row][p]) meet &= dom_q[p];
		meet |= bitv;
	end

	// change and growth seen in the current cycle, so the last row of a round counts
	assign relax_chg = cmd.relax && (meet != dom_q[row]);
	assign dead_hit  = cmd.dead_scan && !dead_q[row] && ((pred_q[row] & ~dead_q) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) pred_q[i] <= '0;
			dead_q <= '0;
			chg_q  <= 1'b0;
			grew_q <= 1'b0;
		end else begin
			if (pm_clear) begin
				for (int i = 0; i < NB; i++) pred_q[i] <= '0;
				dead_q <= '0;
			end else if (pm_wr)
				pred_q[pm_s][pm_p] <= 1'b1;
			if (cmd.clr_chg) begin
				chg_q  <= 1'b0;
				grew_q <= 1'b0;
			end else begin
				if (relax_chg) chg_q <= 1'b1;
				if (dead_hit) grew_q <= 1'b1;
			end
			if (cmd.clr_dead) dead_q <= '0;
			if (dead_hit) dead_q[row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int i = 0; i < NB; i++) dom_q[i] <= all;
			dom_q[0] <= {{(NB-1){1'b0}}, 1'b1};
		end else if (cmd.relax)
			dom_q[row] <= meet;
		else if (cmd.strip)
			dom_q[row] <= dead_q[row] ? '0 : (dom_q[row] & ~dead_q);
	end

	assign sts.changed   = chg_q || relax_chg;
	assign sts.dead_grew = grew_q || dead_hit;
	assign row_set = dom_q[row];
	always_comb for (int i = 0; i < NB; i++) sets_flat[i] = dom_q[i];
endmodule
`default_nettype wire

// ----- design/dsi_controller.sv -----
`default_nettype none
module dsi_controller #(
	parameter int NB = dsi_pkg::MAX_BLOCKS_DEF,
	parameter int IW = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [IW:0]       n,
	input  wire dsi_pkg::dsi_sts_t sts,
	input  wire logic              out_ready,
	output dsi_pkg::dsi_cmd_t      cmd,
	output logic [IW-1:0]          row,
	output logic                   busy,
	output logic                   emit
);
	import dsi_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_RELAX = 3'd1, S_DEAD = 3'd2,
		S_STRIP = 3'd3, S_EMIT = 3'd4;
	logic [2:0]    st_q;
	logic [IW-1:0] row_q;
	logic          row_end;

	assign row_end = ({1'b0, row_q} == n - 1'b1);
	assign row = row_q;
	assign busy = (st_q != S_IDLE);
	assign emit = (st_q == S_EMIT);

	always_comb begin
		cmd = '0;
		case (st_q)
			S_IDLE:  begin
				cmd.init = start;
				cmd.clr_chg = start;
				cmd.clr_dead = start;
			end
			S_RELAX: begin
				cmd.relax = (row_q != '0);
				cmd.clr_chg = row_end;
			end
			S_DEAD:  begin
				cmd.dead_scan = (row_q != '0);
				cmd.clr_chg = row_end;
			end
			S_STRIP: cmd.strip = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			row_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (start) begin
					st_q  <= S_RELAX;
					row_q <= '0;
				end
				S_RELAX: if (row_end) begin
					row_q <= '0;
					if (!sts.changed) st_q <= S_DEAD;
				end else row_q <= row_q + 1'b1;
				S_DEAD: if (row_end) begin
					row_q <= '0;
					if (!sts.dead_grew) st_q <= S_STRIP;
				end else row_q <= row_q + 1'b1;
				S_STRIP: if (row_end) begin
					row_q <= '0;
					st_q  <= S_EMIT;
				end else row_q <= row_q + 1'b1;
				S_EMIT: if (out_ready) begin
					if (row_end) st_q <= S_IDLE;
					else row_q <= row_q + 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/dominator_set_and_idom_engine.sv -----
// channel   dir  payload
// s_axis    in   kind, block_count, pred_block, succ_block
// m_axis    out  block_index, dominator_set, immediate_dominator, flags, tlast
// begin and edge transactions are accepted back to back
// compute: relax rounds (one block per cycle through the meet unit) until a
// round changes no set, then dead scan rounds until a round marks no new block,
// then a strip pass over every block and a result pass that waits out any output stall;
// no input is taken meanwhile
// the idom for each result is searched combinationally over the stored sets
// arst_n clears the predecessor matrix and dead mask, sets the block count to 1 and resets the controller
`default_nettype none
module dominator_set_and_idom_engine #(
	parameter int MAX_BLOCKS = dsi_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // kind, block_count, pred, succ
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // index, set, idom, idom_valid, is_dead
	output logic             m_axis_tlast
);
	import dsi_pkg::*;
	localparam int NB = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
	localparam int IW = $clog2(NB);

	logic [1:0]  kind;
	logic [5:0]  bc;
	logic [4:0]  pb, sb;
	logic        acc, busy, emit, start;
	logic [IW:0] n_q, bcs;
	logic [IW-1:0] row;
	dsi_cmd_t cmd;
	dsi_sts_t sts;
	logic [NB-1:0] row_set, dead, all, strict, kb;
	logic [NB-1:0] sets [NB];
	logic [IW-1:0] idom;
	logic          ivalid;

	assign kind = s_axis_tdata[1:0];
	assign bc   = s_axis_tdata[7:2];
	assign pb   = s_axis_tdata[12:8];
	assign sb   = s_axis_tdata[17:13];
	assign s_axis_tready = !busy;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign start = acc && kind == KIND_COMPUTE;

	always_comb begin
		if (bc == 6'd0) bcs = (IW+1)'(1);
		else if ({1'b0, bc} > 7'(NB)) bcs = (IW+1)'(NB);
		else bcs = bc[IW:0];
		for (int i = 0; i < NB; i++) all[i] = (i < n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_q <= (IW+1)'(1);
		else if (acc && kind == KIND_BEGIN) n_q <= bcs;
	end

	dsi_datapath #(.NB(NB), .IW(IW)) u_dp (
		.clk, .arst_n, .cmd, .row, .all,
		.pm_clear(acc && kind == KIND_BEGIN),
		.pm_wr(acc && kind == KIND_EDGE && {1'b0, pb} < 6'(n_q) && {1'b0, sb} < 6'(n_q)),
		.pm_p(pb[IW-1:0]), .pm_s(sb[IW-1:0]),
		.sts, .row_set, .dead_q(dead), .sets_flat(sets)
	);

	dsi_controller #(.NB(NB), .IW(IW)) u_ctl (
		.clk, .arst_n, .start, .n(n_q), .sts, .out_ready(m_axis_tready),
		.cmd, .row, .busy, .emit
	);

	// idom search: lowest strict dominator k whose set covers all the others
	always_comb begin
		strict = row_set;
		strict[row] = 1'b0;
		idom = '0;
		ivalid = 1'b0;
		for (int k = NB-1; k >= 0; k--) begin
			kb = '0;
			kb[k] = 1'b1;
			if (strict[k] && ((strict & ~kb & ~sets[k]) == '0)) begin
				idom = IW'(k);
				ivalid = 1'b1;
			end
		end
		if (row == '0 || dead[row]) begin
			idom = '0;
			ivalid = 1'b0;
		end
	end

	assign m_axis_tvalid = emit;
	assign m_axis_tlast  = ({1'b0, row} == n_q - 1'b1);
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[4:0]   = 5'(row);
		m_axis_tdata[36:5]  = 32'(row_set);
		m_axis_tdata[41:37] = 5'(idom);
		m_axis_tdata[42]    = ivalid;
		m_axis_tdata[43]    = dead[row];
	end

	`include "dominator_set_and_idom_engine_macros.svh"
	`DSI_ASSERT_IMP(a_no_in_busy, clk, arst_n, busy, !s_axis_tready)
	`DSI_ASSERT_IMP(a_root_noidom, clk, arst_n, emit && row == '0, !ivalid)
	`DSI_ASSERT_IMP(a_dead_empty, clk, arst_n, emit && dead[row], row_set == '0)
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dsi_pkg::*;

	// unused opcode, the block must drop it without results
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam int         CAP           = 32;

	typedef struct {
		logic [4:0]  block_index;
		logic [31:0] dominator_set;
		logic [4:0]  immediate_dominator;
		logic        idom_valid;
		logic        is_dead;
		logic        last;
	} dom_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	dominator_set_and_idom_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	// shadow copy of the graph and working sets
	logic [31:0] graph_preds [CAP];
	logic [31:0] shadow_sets [CAP];
	logic [5:0]  graph_size;
	dom_result_t dominator_queue [$];
	int          error_count = 0;
	int          burst_left = 0;
	int          stall_mode = 0;

	task automatic graph_clear();
		for (int b = 0; b < CAP; b++) begin
			graph_preds[b] = '0;
			shadow_sets[b] = '0;
		end
		graph_size = 6'd1;
	endtask

	// runs the dataflow rounds, dead-block pass and idom search for one compute
	task automatic predict_dominators();
		int          n;
		logic [31:0] full, meet, dead, strict, bit_k;
		logic        changed, grew;
		dom_result_t r;
		n = graph_size;
		full = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 1);
		shadow_sets[0] = 32'd1;
		for (int b = 1; b < n; b++)
			shadow_sets[b] = full;
		changed = 1'b1;
		while (changed) begin
			changed = 1'b0;
			for (int b = 1; b < n; b++) begin
				meet = full;
				for (int p = 0; p < n; p++)
					if (graph_preds[b][p])
						meet &= shadow_sets[p];
				meet |= 32'd1 << b;
				if (meet != shadow_sets[b]) begin
					shadow_sets[b] = meet;
					changed = 1'b1;
				end
			end
		end
		// least fixpoint: blocks fed only by dead blocks (or by nothing)
		dead = '0;
		grew = 1'b1;
		while (grew) begin
			grew = 1'b0;
			for (int b = 1; b < n; b++)
				if (!dead[b] && (graph_preds[b] & ~dead) == 0) begin
					dead[b] = 1'b1;
					grew = 1'b1;
				end
		end
		for (int b = 0; b < n; b++)
			shadow_sets[b] = dead[b] ? 32'd0 : (shadow_sets[b] & ~dead);
		for (int b = 0; b < n; b++) begin
			r.block_index = b[4:0];
			r.dominator_set = shadow_sets[b];
			r.immediate_dominator = '0;
			r.idom_valid = 1'b0;
			r.is_dead = dead[b];
			r.last = (b + 1 == n);
			if (b != 0 && !dead[b]) begin
				strict = shadow_sets[b] & ~(32'd1 << b);
				for (int k = 0; k < n; k++) begin
					bit_k = 32'd1 << k;
					if (!r.idom_valid && (strict & bit_k) != 0
							&& ((strict & ~bit_k) & ~shadow_sets[k]) == 0) begin
						r.immediate_dominator = k[4:0];
						r.idom_valid = 1'b1;
					end
				end
			end
			dominator_queue = {dominator_queue, r};
		end
	endtask

	task automatic graph_accept(input logic [1:0] kind, input logic [5:0] count,
			input logic [4:0] pred, input logic [4:0] succ);
		case (kind)
			KIND_BEGIN: begin
				graph_clear();
				graph_size = (count == 0) ? 6'd1 : ((count > CAP) ? 6'(CAP) : count);
			end
			KIND_EDGE: begin
				if (pred < graph_size && succ < graph_size)
					graph_preds[succ][pred] = 1'b1;
			end
			KIND_COMPUTE: predict_dominators();
			default: ;
		endcase
	endtask

	// one transaction on the input side; gaps come between bursts
	task automatic send_item(input logic [1:0] kind, input logic [5:0] count = 6'd0,
			input logic [4:0] pred = 5'd0, input logic [4:0] succ = 5'd0);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, succ, pred, count, kind};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		graph_accept(kind, count, pred, succ);
	endtask

	task automatic begin_graph(input int n);
		send_item(KIND_BEGIN, 6'(n));
	endtask

	task automatic add_edge(input int p, input int s);
		send_item(KIND_EDGE, 6'($urandom_range(0, 63)), 5'(p), 5'(s));
	endtask

	// block 0 alone, before any begin transaction
	task automatic test_compute_after_reset();
		send_item(KIND_COMPUTE);
	endtask

	// count of zero and counts beyond capacity
	task automatic test_count_limits();
		begin_graph(0);
		send_item(KIND_COMPUTE);
		begin_graph(63);
		add_edge(0, 31);
		add_edge(31, 30);
		send_item(KIND_COMPUTE);
	endtask

	// diamond with self edge, duplicate edge, out of range edge, dead loop, kind 3
	task automatic test_diamond_and_dead();
		begin_graph(7);
		add_edge(0, 1);
		add_edge(0, 2);
		add_edge(1, 3);
		add_edge(2, 3);
		add_edge(2, 3);
		add_edge(3, 3);
		add_edge(3, 7);
		add_edge(5, 6);
		add_edge(6, 5);
		add_edge(5, 3);
		send_item(KIND_RESERVED, 6'd63, 5'd31, 5'd31);
		send_item(KIND_COMPUTE);
	endtask

	// random graphs: mostly connected small ones, some full size, some noise
	task automatic test_random_graphs();
		int items, n, edges, kind_pick;
		items = 0;
		while (items < 80) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 9);
			begin_graph(n);
			if (n == 0)
				n = 1;
			if (n > CAP)
				n = CAP;
			edges = $urandom_range(n / 2, n + 3);
			if (edges > 40)
				edges = 40;
			for (int e = 0; e < edges; e++) begin
				kind_pick = $urandom_range(0, 15);
				if (kind_pick == 0)
					send_item(KIND_RESERVED, 6'($urandom_range(0, 63)),
						5'($urandom), 5'($urandom));
				else if (kind_pick == 1)
					add_edge($urandom_range(0, 31), $urandom_range(0, 31));
				else if (kind_pick < 11 && n > 1) begin
					// forward edge from a lower block keeps most blocks reachable
					int s;
					s = $urandom_range(1, n - 1);
					add_edge($urandom_range(0, s - 1), s);
				end else
					add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
			end
			send_item(KIND_COMPUTE);
			items += edges + 2;
		end
	endtask

	// receiver stalls: phases of always ready, random, and heavy stall
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin
		dom_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (dominator_queue.size() == 0) begin
				$error("unexpected result, block_index %0d", m_axis_tdata[4:0]);
				error_count++;
			end else begin
				want = dominator_queue.pop_front();
				if (m_axis_tdata[4:0] !== want.block_index) begin
					$error("block_index expected %0d got %0d", want.block_index,
						m_axis_tdata[4:0]);
					error_count++;
				end
				if (m_axis_tdata[36:5] !== want.dominator_set) begin
					$error("dominator_set expected %h got %h", want.dominator_set,
						m_axis_tdata[36:5]);
					error_count++;
				end
				if (m_axis_tdata[41:37] !== want.immediate_dominator) begin
					$error("immediate_dominator expected %0d got %0d",
						want.immediate_dominator, m_axis_tdata[41:37]);
					error_count++;
				end
				if (m_axis_tdata[42] !== want.idom_valid) begin
					$error("idom_valid expected %0d got %0d", want.idom_valid,
						m_axis_tdata[42]);
					error_count++;
				end
				if (m_axis_tdata[43] !== want.is_dead) begin
					$error("is_dead expected %0d got %0d", want.is_dead, m_axis_tdata[43]);
					error_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last expected %0d got %0d", want.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	initial begin
		graph_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_compute_after_reset();
		test_count_limits();
		test_diamond_and_dead();
		test_random_graphs();
		s_axis_tvalid <= 1'b0;
		while (dominator_queue.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#4ms;
		$display("testbench: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/dsi_pkg.sv
design/dsi_datapath.sv
design/dsi_controller.sv
design/dominator_set_and_idom_engine.sv
test/testbench.sv
